@@ design/gcffa_pkg.sv @@
// Shared types and constants for the grid cell first-free allocator.
package gcffa_pkg;

  localparam int CELLS_PER_SIDE_DEF = 16;

  localparam int COORD_W    = 4;
  localparam int CELL_PIX_W = 9;
  localparam int SHEET_W    = 8;
  localparam int PIX_W      = 12;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [PIX_W-1:0]      PIX_MAX          = 12'd4095;
  localparam logic [CELL_PIX_W-1:0] CELL_PIX_RST     = 9'd16;
  localparam logic [SHEET_W-1:0]    SHEET_RST        = 8'd0;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOT_USED = 2'd2
  } status_t;

  typedef enum logic {
    REG_CELL_PIXELS = 1'b0,
    REG_SHEET       = 1'b1
  } reg_idx_t;

  // Update of one occupancy bit.
  typedef struct packed {
    logic en;
    logic set_bit;
  } map_op_t;

endpackage

@@ design/gcffa_cfg.sv @@
// Configuration registers behind the APB-style port.
module gcffa_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gcffa_pkg::PADDR_W-1:0]       paddr,
  input  logic [gcffa_pkg::PDATA_W-1:0]       pwdata,
  output logic [gcffa_pkg::PDATA_W-1:0]       prdata,
  output logic [gcffa_pkg::CELL_PIX_W-1:0]    cell_pixels,
  output logic [gcffa_pkg::SHEET_W-1:0]       sheet_number
);

  logic [gcffa_pkg::CELL_PIX_W-1:0] cell_pixels_r;
  logic [gcffa_pkg::SHEET_W-1:0]    sheet_number_r;
  logic                             wr_en;
  gcffa_pkg::reg_idx_t              reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = gcffa_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_pixels_r  <= gcffa_pkg::CELL_PIX_RST;
      sheet_number_r <= gcffa_pkg::SHEET_RST;
    end else if (wr_en) begin
      case (reg_idx)
        gcffa_pkg::REG_CELL_PIXELS: cell_pixels_r  <= pwdata[gcffa_pkg::CELL_PIX_W-1:0];
        gcffa_pkg::REG_SHEET:       sheet_number_r <= pwdata[gcffa_pkg::SHEET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gcffa_pkg::REG_CELL_PIXELS:
        prdata = {{(gcffa_pkg::PDATA_W-gcffa_pkg::CELL_PIX_W){1'b0}}, cell_pixels_r};
      gcffa_pkg::REG_SHEET:
        prdata = {{(gcffa_pkg::PDATA_W-gcffa_pkg::SHEET_W){1'b0}}, sheet_number_r};
      default: prdata = '0;
    endcase
  end

  assign cell_pixels  = cell_pixels_r;
  assign sheet_number = sheet_number_r;

endmodule

@@ design/gcffa_bitmap.sv @@
// Occupancy bitmap: one flop per cell, cleared at reset.
module gcffa_bitmap #(
  parameter int CELLS_PER_SIDE = gcffa_pkg::CELLS_PER_SIDE_DEF,
  localparam int IDX_W = (CELLS_PER_SIDE > 1) ? $clog2(CELLS_PER_SIDE) : 1
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  gcffa_pkg::map_op_t                            op,
  input  logic [IDX_W-1:0]                              op_row,
  input  logic [IDX_W-1:0]                              op_col,
  output logic [CELLS_PER_SIDE-1:0][CELLS_PER_SIDE-1:0] occ
);

  logic [CELLS_PER_SIDE-1:0][CELLS_PER_SIDE-1:0] occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (op.en) begin
      occ_r[op_row][op_col] <= op.set_bit;
    end
  end

  assign occ = occ_r;

endmodule

@@ design/gcffa_find.sv @@
// First free cell search in row-major order over the occupancy bitmap.
module gcffa_find #(
  parameter int CELLS_PER_SIDE = gcffa_pkg::CELLS_PER_SIDE_DEF,
  localparam int IDX_W = (CELLS_PER_SIDE > 1) ? $clog2(CELLS_PER_SIDE) : 1
) (
  input  logic [CELLS_PER_SIDE-1:0][CELLS_PER_SIDE-1:0] occ,
  output logic                                          found,
  output logic [IDX_W-1:0]                              found_row,
  output logic [IDX_W-1:0]                              found_col
);

  logic [CELLS_PER_SIDE-1:0] row_has_free;
  logic [CELLS_PER_SIDE-1:0] row_word;

  // Rows with a free cell, then lowest such row.
  always_comb begin
    row_has_free = '0;
    found_row    = '0;
    for (int r = CELLS_PER_SIDE - 1; r >= 0; r--) begin
      row_has_free[r] = ~&occ[r];
      if (row_has_free[r]) begin
        found_row = IDX_W'(r);
      end
    end
  end

  assign found    = |row_has_free;
  assign row_word = occ[found_row];

  // Lowest free column within the chosen row.
  always_comb begin
    found_col = '0;
    for (int c = CELLS_PER_SIDE - 1; c >= 0; c--) begin
      if (!row_word[c]) begin
        found_col = IDX_W'(c);
      end
    end
  end

endmodule

@@ design/grid_cell_first_free_allocator.sv @@
// Top level of the grid cell first-free allocator.
//
//  channel | handshake                     | payload
//  --------+-------------------------------+----------------------------------------
//  in      | in_valid / in_ready           | cmd, free_column, free_row
//  out     | out_valid / out_ready         | status, cell_column, cell_row,
//          |                               | pixel_left, pixel_top, sheet_out
//  cfg     | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One item per cycle sustained while out_ready stays high; a result is offered
// once its item has moved from the input register into the result register.
// The search, bitmap update and pixel multiply all fit between those two registers.
// A stalled result holds in the result register; the input register still
// takes one more item and then in_ready drops until the result moves.
// rst_n is synchronous: it clears all cells to free and loads the register defaults.
module grid_cell_first_free_allocator #(
  parameter int CELLS_PER_SIDE = gcffa_pkg::CELLS_PER_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [gcffa_pkg::COORD_W-1:0]       in_free_column,
  input  logic [gcffa_pkg::COORD_W-1:0]       in_free_row,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [gcffa_pkg::COORD_W-1:0]       out_cell_column,
  output logic [gcffa_pkg::COORD_W-1:0]       out_cell_row,
  output logic [gcffa_pkg::PIX_W-1:0]         out_pixel_left,
  output logic [gcffa_pkg::PIX_W-1:0]         out_pixel_top,
  output logic [gcffa_pkg::SHEET_W-1:0]       out_sheet_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gcffa_pkg::PADDR_W-1:0]       paddr,
  input  logic [gcffa_pkg::PDATA_W-1:0]       pwdata,
  output logic [gcffa_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  localparam int IDX_W  = (CELLS_PER_SIDE > 1) ? $clog2(CELLS_PER_SIDE) : 1;
  localparam int EXT_W  = 7;
  localparam int PROD_W = IDX_W + gcffa_pkg::CELL_PIX_W;
  localparam logic [EXT_W-1:0] SIDE_EXT = EXT_W'(CELLS_PER_SIDE);

  // Saturating pixel position.
  function automatic logic [gcffa_pkg::PIX_W-1:0] pix_sat(input logic [PROD_W-1:0] prod);
    logic [PROD_W+gcffa_pkg::PIX_W-1:0] wide;
    wide = {{gcffa_pkg::PIX_W{1'b0}}, prod};
    if (wide > (PROD_W + gcffa_pkg::PIX_W)'(gcffa_pkg::PIX_MAX)) begin
      pix_sat = gcffa_pkg::PIX_MAX;
    end else begin
      pix_sat = wide[gcffa_pkg::PIX_W-1:0];
    end
  endfunction

  logic [gcffa_pkg::CELL_PIX_W-1:0] cell_pixels;
  logic [gcffa_pkg::SHEET_W-1:0]    sheet_number;

  // Input register.
  logic                            in_vld_r;
  gcffa_pkg::cmd_t                 cmd_r;
  logic [gcffa_pkg::COORD_W-1:0]   col_r;
  logic [gcffa_pkg::COORD_W-1:0]   row_r;

  // Result register.
  logic                            out_vld_r;
  gcffa_pkg::status_t              status_r,   status_nxt;
  logic [gcffa_pkg::COORD_W-1:0]   ccol_r,     ccol_nxt;
  logic [gcffa_pkg::COORD_W-1:0]   crow_r,     crow_nxt;
  logic [gcffa_pkg::PIX_W-1:0]     left_r,     left_nxt;
  logic [gcffa_pkg::PIX_W-1:0]     top_r,      top_nxt;
  logic [gcffa_pkg::SHEET_W-1:0]   sheet_r,    sheet_nxt;

  logic [CELLS_PER_SIDE-1:0][CELLS_PER_SIDE-1:0] occ;
  logic                 found;
  logic [IDX_W-1:0]     found_row;
  logic [IDX_W-1:0]     found_col;
  logic                 proc;
  logic [EXT_W-1:0]     fcol_ext;
  logic [EXT_W-1:0]     frow_ext;
  logic [EXT_W-1:0]     acol_ext;
  logic [EXT_W-1:0]     arow_ext;
  logic                 free_in_range;
  logic                 free_used;
  logic [PROD_W-1:0]    left_prod;
  logic [PROD_W-1:0]    top_prod;
  gcffa_pkg::map_op_t   map_op;
  logic [IDX_W-1:0]     op_row;
  logic [IDX_W-1:0]     op_col;

  gcffa_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .cell_pixels  (cell_pixels),
    .sheet_number (sheet_number)
  );

  gcffa_bitmap #(.CELLS_PER_SIDE(CELLS_PER_SIDE)) u_bitmap (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (map_op),
    .op_row (op_row),
    .op_col (op_col),
    .occ    (occ)
  );

  gcffa_find #(.CELLS_PER_SIDE(CELLS_PER_SIDE)) u_find (
    .occ       (occ),
    .found     (found),
    .found_row (found_row),
    .found_col (found_col)
  );

  assign pready = 1'b1;

  // Advance the held item when the result register is free or draining.
  assign proc     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r <= gcffa_pkg::cmd_t'(in_cmd);
      col_r <= in_free_column;
      row_r <= in_free_row;
    end
  end

  // Free request: range check and current bit.
  assign fcol_ext      = {{(EXT_W-gcffa_pkg::COORD_W){1'b0}}, col_r};
  assign frow_ext      = {{(EXT_W-gcffa_pkg::COORD_W){1'b0}}, row_r};
  assign free_in_range = (fcol_ext < SIDE_EXT) && (frow_ext < SIDE_EXT);
  assign free_used     = free_in_range && occ[frow_ext[IDX_W-1:0]][fcol_ext[IDX_W-1:0]];

  // Allocation coordinates and pixel positions.
  assign acol_ext  = EXT_W'(found_col);
  assign arow_ext  = EXT_W'(found_row);
  assign left_prod = PROD_W'(found_col) * PROD_W'(cell_pixels);
  assign top_prod  = PROD_W'(found_row) * PROD_W'(cell_pixels);

  always_comb begin
    map_op.en      = 1'b0;
    map_op.set_bit = 1'b0;
    op_row         = found_row;
    op_col         = found_col;
    status_nxt     = gcffa_pkg::STATUS_DONE;
    ccol_nxt       = '0;
    crow_nxt       = '0;
    left_nxt       = '0;
    top_nxt        = '0;
    sheet_nxt      = '0;
    case (cmd_r)
      gcffa_pkg::CMD_ALLOC: begin
        if (found) begin
          map_op.en      = proc;
          map_op.set_bit = 1'b1;
          ccol_nxt       = acol_ext[gcffa_pkg::COORD_W-1:0];
          crow_nxt       = arow_ext[gcffa_pkg::COORD_W-1:0];
          left_nxt       = pix_sat(left_prod);
          top_nxt        = pix_sat(top_prod);
          sheet_nxt      = sheet_number;
        end else begin
          status_nxt = gcffa_pkg::STATUS_FULL;
        end
      end
      gcffa_pkg::CMD_FREE: begin
        op_row = frow_ext[IDX_W-1:0];
        op_col = fcol_ext[IDX_W-1:0];
        if (free_used) begin
          map_op.en = proc;
        end else begin
          status_nxt = gcffa_pkg::STATUS_NOT_USED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      status_r <= status_nxt;
      ccol_r   <= ccol_nxt;
      crow_r   <= crow_nxt;
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      sheet_r  <= sheet_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = status_r;
  assign out_cell_column = ccol_r;
  assign out_cell_row    = crow_r;
  assign out_pixel_left  = left_r;
  assign out_pixel_top   = top_r;
  assign out_sheet_out   = sheet_r;

endmodule

@@ design/gcffa_checker.sv @@
// Port-level checks for the grid cell first-free allocator, bound to the top level.
module gcffa_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [1:0]                          out_status,
  input logic [gcffa_pkg::COORD_W-1:0]       out_cell_column,
  input logic [gcffa_pkg::COORD_W-1:0]       out_cell_row,
  input logic [gcffa_pkg::PIX_W-1:0]         out_pixel_left,
  input logic [gcffa_pkg::PIX_W-1:0]         out_pixel_top,
  input logic [gcffa_pkg::SHEET_W-1:0]       out_sheet_out
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Any result other than a completed one (full or not in use) carries zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != gcffa_pkg::STATUS_DONE) |->
      (out_cell_column == '0 && out_cell_row == '0 && out_pixel_left == '0 &&
       out_pixel_top == '0 && out_sheet_out == '0))
    else $error("nonzero fields on full or not-in-use result");

  // With the result register empty the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_cell_column) &&
       $stable(out_cell_row) && $stable(out_pixel_left) &&
       $stable(out_pixel_top) && $stable(out_sheet_out)))
    else $error("stalled result changed");

endmodule

bind grid_cell_first_free_allocator gcffa_checker u_gcffa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_cell_column (out_cell_column),
  .out_cell_row    (out_cell_row),
  .out_pixel_left  (out_pixel_left),
  .out_pixel_top   (out_pixel_top),
  .out_sheet_out   (out_sheet_out)
);

@@ tb/gcffa_checker.sv @@
// Checker for the grid cell allocator: tracks occupancy and registers, compares every result.
`timescale 1ns / 100ps
module gcffa_scoreboard (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_cmd,
  input  logic [gcffa_pkg::COORD_W-1:0]    in_free_column,
  input  logic [gcffa_pkg::COORD_W-1:0]    in_free_row,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       out_status,
  input  logic [gcffa_pkg::COORD_W-1:0]    out_cell_column,
  input  logic [gcffa_pkg::COORD_W-1:0]    out_cell_row,
  input  logic [gcffa_pkg::PIX_W-1:0]      out_pixel_left,
  input  logic [gcffa_pkg::PIX_W-1:0]      out_pixel_top,
  input  logic [gcffa_pkg::SHEET_W-1:0]    out_sheet_out,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [gcffa_pkg::PADDR_W-1:0]    paddr,
  input  logic [gcffa_pkg::PDATA_W-1:0]    pwdata,
  output int                               fail_count,
  output int                               pending
);

  typedef struct packed {
    gcffa_pkg::status_t                status;
    logic [gcffa_pkg::COORD_W-1:0]     column;
    logic [gcffa_pkg::COORD_W-1:0]     row;
    logic [gcffa_pkg::PIX_W-1:0]       left;
    logic [gcffa_pkg::PIX_W-1:0]       top;
    logic [gcffa_pkg::SHEET_W-1:0]     sheet;
  } answer_t;

  logic [gcffa_pkg::CELLS_PER_SIDE_DEF-1:0] used_map [gcffa_pkg::CELLS_PER_SIDE_DEF];
  logic [gcffa_pkg::CELL_PIX_W-1:0]         cell_pix = gcffa_pkg::CELL_PIX_RST;
  logic [gcffa_pkg::SHEET_W-1:0]            sheet_id = gcffa_pkg::SHEET_RST;
  answer_t                                  answers_due[$];
  int                                       mismatches = 0;
  int                                       outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic logic [gcffa_pkg::PIX_W-1:0] pixel_of(input int idx);
    int unsigned p;
    p = idx * int'(cell_pix);
    return (p > gcffa_pkg::PIX_MAX) ? gcffa_pkg::PIX_MAX : gcffa_pkg::PIX_W'(p);
  endfunction

  // Apply one request to the occupancy map and return the answer it earns.
  function automatic answer_t serve_request(input gcffa_pkg::cmd_t c,
                                            input logic [gcffa_pkg::COORD_W-1:0] col,
                                            input logic [gcffa_pkg::COORD_W-1:0] row);
    answer_t a;
    a = '0;
    if (c == gcffa_pkg::CMD_ALLOC) begin
      a.status = gcffa_pkg::STATUS_FULL;
      for (int y = 0; y < gcffa_pkg::CELLS_PER_SIDE_DEF; y++) begin
        for (int x = 0; x < gcffa_pkg::CELLS_PER_SIDE_DEF; x++) begin
          if (a.status == gcffa_pkg::STATUS_FULL && !used_map[y][x]) begin
            used_map[y][x] = 1'b1;
            a.status = gcffa_pkg::STATUS_DONE;
            a.column = gcffa_pkg::COORD_W'(x);
            a.row    = gcffa_pkg::COORD_W'(y);
            a.left   = pixel_of(x);
            a.top    = pixel_of(y);
            a.sheet  = sheet_id;
          end
        end
      end
    end else if (used_map[row][col]) begin
      used_map[row][col] = 1'b0;
      a.status = gcffa_pkg::STATUS_DONE;
    end else begin
      a.status = gcffa_pkg::STATUS_NOT_USED;
    end
    return a;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      for (int y = 0; y < gcffa_pkg::CELLS_PER_SIDE_DEF; y++) used_map[y] = '0;
      cell_pix = gcffa_pkg::CELL_PIX_RST;
      sheet_id = gcffa_pkg::SHEET_RST;
      answers_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (gcffa_pkg::reg_idx_t'(paddr[2]))
          gcffa_pkg::REG_CELL_PIXELS: cell_pix = pwdata[gcffa_pkg::CELL_PIX_W-1:0];
          gcffa_pkg::REG_SHEET:       sheet_id = pwdata[gcffa_pkg::SHEET_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result, status %0d column %0d row %0d left %0d top %0d sheet %0d",
                   $time, out_status, out_cell_column, out_cell_row, out_pixel_left,
                   out_pixel_top, out_sheet_out);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("cell_column", want.column, out_cell_column);
          compare_field("cell_row", want.row, out_cell_row);
          compare_field("pixel_left", want.left, out_pixel_left);
          compare_field("pixel_top", want.top, out_pixel_top);
          compare_field("sheet_out", want.sheet, out_sheet_out);
        end
      end
      if (in_valid && in_ready)
        answers_due.push_back(serve_request(gcffa_pkg::cmd_t'(in_cmd), in_free_column,
                                            in_free_row));
    end
    // Publish the count with a nonblocking assignment so readers at the clock edge see a settled value.
    outstanding <= answers_due.size();
  end

endmodule

@@ tb/tb.sv @@
// Top of the grid cell allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;

  localparam int LONG_HOLD = 40;
  localparam int CW        = gcffa_pkg::COORD_W;

  logic                             clk            = 1'b0;
  logic                             rst_n          = 1'b0;
  logic                             in_valid       = 1'b0;
  logic                             in_ready;
  logic                             in_cmd         = gcffa_pkg::CMD_ALLOC;
  logic [CW-1:0]                    in_free_column = '0;
  logic [CW-1:0]                    in_free_row    = '0;
  logic                             out_valid;
  logic                             out_ready      = 1'b0;
  logic [1:0]                       out_status;
  logic [CW-1:0]                    out_cell_column;
  logic [CW-1:0]                    out_cell_row;
  logic [gcffa_pkg::PIX_W-1:0]      out_pixel_left;
  logic [gcffa_pkg::PIX_W-1:0]      out_pixel_top;
  logic [gcffa_pkg::SHEET_W-1:0]    out_sheet_out;
  logic                             psel           = 1'b0;
  logic                             penable        = 1'b0;
  logic                             pwrite         = 1'b0;
  logic [gcffa_pkg::PADDR_W-1:0]    paddr          = '0;
  logic [gcffa_pkg::PDATA_W-1:0]    pwdata         = '0;
  logic [gcffa_pkg::PDATA_W-1:0]    prdata;
  logic                             pready;
  int                               fail_count;
  int                               pending;

  bit                               gaps_on       = 1'b0;
  bit                               long_hold_req = 1'b0;
  int                               full_seen     = 0;
  gcffa_pkg::cmd_t                  cmds_in_flight[$];
  logic [2*CW-1:0]                  live_cells[$];

  grid_cell_first_free_allocator uut (.*);
  gcffa_scoreboard u_scoreboard (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stall per item, plus one long hold-off on request.
  initial begin : receiver
    int              stall;
    gcffa_pkg::cmd_t c;
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        stall = gaps_on ? $urandom_range(0, 10) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!(rst_n && out_valid === 1'b1));
        if (cmds_in_flight.size() > 0) begin
          c = cmds_in_flight.pop_front();
          if (c == gcffa_pkg::CMD_ALLOC && out_status == gcffa_pkg::STATUS_DONE)
            live_cells.push_back({out_cell_row, out_cell_column});
          if (out_status == gcffa_pkg::STATUS_FULL) full_seen++;
        end
      end
    end
  end

  task automatic send_item(input gcffa_pkg::cmd_t c, input logic [CW-1:0] col,
                           input logic [CW-1:0] row);
    int gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= c;
    in_free_column <= col;
    in_free_row    <= row;
    do @(posedge clk); while (in_ready !== 1'b1);
    cmds_in_flight.push_back(c);
  endtask

  // Mostly allocations and frees of cells known to be held; the rest random frees.
  task automatic send_random(input int alloc_pct, input int noise_pct);
    int              roll;
    int              k;
    logic [2*CW-1:0] spot;
    roll = $urandom_range(0, 99);
    spot = (2*CW)'($urandom);
    if (roll < alloc_pct) begin
      send_item(gcffa_pkg::CMD_ALLOC, spot[CW-1:0], spot[2*CW-1:CW]);
    end else if (roll < alloc_pct + noise_pct || live_cells.size() == 0) begin
      send_item(gcffa_pkg::CMD_FREE, spot[CW-1:0], spot[2*CW-1:CW]);
    end else begin
      k = $urandom_range(0, live_cells.size() - 1);
      spot = live_cells[k];
      live_cells.delete(k);
      send_item(gcffa_pkg::CMD_FREE, spot[CW-1:0], spot[2*CW-1:CW]);
    end
  endtask

  task automatic wait_all_answered();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input gcffa_pkg::reg_idx_t idx,
                           input logic [gcffa_pkg::PDATA_W-1:0] value);
    in_valid <= 1'b0;
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b1;
    paddr    <= {idx, 2'b00};
    pwdata   <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Idle between transfers.
    @(posedge clk);
  endtask

  // Upper data bits are random; the block keeps only the register width.
  task automatic configure(input int unsigned cell_px, input int unsigned sheet);
    wait_all_answered();
    cfg_write(gcffa_pkg::REG_CELL_PIXELS, ($urandom & ~32'h1FF) | cell_px);
    cfg_write(gcffa_pkg::REG_SHEET, ($urandom & ~32'hFF) | sheet);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on reset register values.
    send_item(gcffa_pkg::CMD_FREE, 4'd0, 4'd0);
    send_item(gcffa_pkg::CMD_FREE, 4'd15, 4'd15);
    send_item(gcffa_pkg::CMD_ALLOC, 4'd15, 4'd15);
    send_item(gcffa_pkg::CMD_ALLOC, 4'd0, 4'd0);
    send_item(gcffa_pkg::CMD_ALLOC, 4'd10, 4'd5);
    send_item(gcffa_pkg::CMD_FREE, 4'd1, 4'd0);
    send_item(gcffa_pkg::CMD_FREE, 4'd1, 4'd0);
    send_item(gcffa_pkg::CMD_ALLOC, 4'd0, 4'd0);
    send_item(gcffa_pkg::CMD_FREE, 4'd2, 4'd0);
    send_item(gcffa_pkg::CMD_FREE, 4'd0, 4'd15);
    configure(0, 255);
    send_item(gcffa_pkg::CMD_ALLOC, 4'd5, 4'd10);
    send_item(gcffa_pkg::CMD_ALLOC, 4'd0, 4'd0);
    configure(511, 0);
    send_item(gcffa_pkg::CMD_ALLOC, 4'd0, 4'd0);
    send_item(gcffa_pkg::CMD_FREE, 4'd0, 4'd0);
    send_item(gcffa_pkg::CMD_FREE, 4'd1, 4'd0);

    // Mixed traffic with zero cell size and the top sheet number.
    gaps_on = 1'b1;
    configure(0, 255);
    repeat (120) send_random(55, 15);

    // Fill the sheet back to back under a long receiver hold, then run past full.
    configure(511, 0);
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    full_seen = 0;
    for (int n = 0; n < 300 && full_seen == 0; n++)
      send_item(gcffa_pkg::CMD_ALLOC, CW'($urandom), CW'($urandom));
    send_item(gcffa_pkg::CMD_ALLOC, 4'd15, 4'd15);
    send_item(gcffa_pkg::CMD_ALLOC, 4'd0, 4'd0);
    wait_all_answered();

    // Mostly releases.
    gaps_on = 1'b1;
    configure(256, $urandom_range(0, 255));
    repeat (150) send_random(15, 15);

    // Alternate stretches with and without idling.
    configure(1, $urandom_range(0, 255));
    for (int n = 0; n < 150; n++) begin
      gaps_on = ((n / 25) % 2) == 0;
      send_random(50, 10);
    end

    gaps_on = 1'b1;
    configure($urandom_range(1, 256), $urandom_range(0, 255));
    repeat (100) send_random(50, 20);

    wait_all_answered();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
design/gcffa_pkg.sv
design/gcffa_cfg.sv
design/gcffa_bitmap.sv
design/gcffa_find.sv
design/grid_cell_first_free_allocator.sv
design/gcffa_checker.sv
tb/gcffa_checker.sv
tb/tb.sv
